// ===== rtl/hcbd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; the RTL files use it by scoped names, the testbench imports it.
package hcbd_pkg;

    localparam int LENGTH_BITS = 32;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [2:0] {
        K_FRAME   = 3'd0,
        K_PAYLOAD = 3'd1,
        K_ERROR   = 3'd2,
        K_DONE    = 3'd3,
        K_LEFT    = 3'd4
    } t_kind;

    typedef enum logic [0:0] {
        ACT_BYTE    = 1'b0,
        ACT_RESTART = 1'b1
    } t_action;

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } t_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic       chunk_last;
    } t_result;

endpackage

// ===== rtl/hcbd_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input bytes and the classified results.
// Depends on hcbd_pkg for the kind type.
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;

    modport source (output valid, output action, output in_byte, input ready);
    modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface hcbd_out_if;
    logic                valid;
    logic                ready;
    hcbd_pkg::t_kind     kind;
    logic [7:0]          payload_byte;
    logic                chunk_last;

    modport source (output valid, output kind, output payload_byte, output chunk_last,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input chunk_last,
                    output ready);
endinterface

// ===== rtl/hcbd_in_stage.sv =====
`timescale 1ns / 1ps
// Input register: captures one transaction and holds it until the core takes it.
// Depends on hcbd_pkg.
module hcbd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hcbd_pkg::t_item     i_item,
    output logic                o_ready,
    output logic                o_valid,
    output hcbd_pkg::t_item     o_item,
    input  logic                i_take
);
    logic            r_valid;
    hcbd_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end
endmodule

// ===== rtl/hcbd_core.sv =====
`timescale 1ns / 1ps
// Chunk framing parser: phase and length counter, and per-byte classification.
// Depends on hcbd_pkg.
module hcbd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  hcbd_pkg::t_item     i_item,
    output hcbd_pkg::t_result   o_result
);
    typedef enum logic [3:0] {
        PH_LEN      = 4'd0,
        PH_LEN_LF   = 4'd1,
        PH_DATA     = 4'd2,
        PH_DATA_END = 4'd3,
        PH_DATA_LF  = 4'd4,
        PH_LAST     = 4'd5,
        PH_LAST_LF  = 4'd6,
        PH_DONE     = 4'd7,
        PH_ERR      = 4'd8
    } t_phase;

    localparam int LW = hcbd_pkg::LENGTH_BITS;

    t_phase        r_phase, n_phase;
    logic [LW-1:0] r_remaining, n_remaining;
    logic [4:0]    hex_d;   // bit 4 set: not a hex digit
    logic [7:0]    c;
    t_phase        len_done_phase;

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39)      v = {1'b0, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) v = {1'b0, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) v = {1'b0, 4'(b - 8'h37)};
        return v;
    endfunction

    assign c              = i_item.in_byte;
    assign hex_d          = hex_val(c);
    assign len_done_phase = (r_remaining == '0) ? PH_LAST : PH_DATA;

    always_comb begin
        n_phase                = r_phase;
        n_remaining            = r_remaining;
        o_result.kind          = hcbd_pkg::K_FRAME;
        o_result.payload_byte  = 8'd0;
        o_result.chunk_last    = 1'b0;
        if (i_item.action == hcbd_pkg::ACT_RESTART) begin
            n_phase     = PH_LEN;
            n_remaining = '0;
        end else begin
            unique case (r_phase)
                PH_LEN: begin
                    if (c == hcbd_pkg::CH_CR) begin
                        n_phase = PH_LEN_LF;
                    end else if (c == hcbd_pkg::CH_LF) begin
                        n_phase = len_done_phase;
                    end else if (hex_d[4] || r_remaining[LW-1 -: 4] != 4'd0) begin
                        n_phase       = PH_ERR;
                        o_result.kind = hcbd_pkg::K_ERROR;
                    end else begin
                        n_remaining = {r_remaining[LW-5:0], hex_d[3:0]};
                    end
                end
                PH_LEN_LF: begin
                    if (c == hcbd_pkg::CH_LF) begin
                        n_phase = len_done_phase;
                    end else begin
                        n_phase       = PH_ERR;
                        o_result.kind = hcbd_pkg::K_ERROR;
                    end
                end
                PH_DATA: begin
                    o_result.kind         = hcbd_pkg::K_PAYLOAD;
                    o_result.payload_byte = c;
                    if (r_remaining <= LW'(1)) begin
                        n_remaining         = '0;
                        o_result.chunk_last = 1'b1;
                        n_phase             = PH_DATA_END;
                    end else begin
                        n_remaining = r_remaining - LW'(1);
                    end
                end
                PH_DATA_END: begin
                    if (c == hcbd_pkg::CH_CR) begin
                        n_phase = PH_DATA_LF;
                    end else if (c == hcbd_pkg::CH_LF) begin
                        n_phase = PH_LEN;
                    end else begin
                        n_phase       = PH_ERR;
                        o_result.kind = hcbd_pkg::K_ERROR;
                    end
                end
                PH_DATA_LF: begin
                    if (c == hcbd_pkg::CH_LF) begin
                        n_phase = PH_LEN;
                    end else begin
                        n_phase       = PH_ERR;
                        o_result.kind = hcbd_pkg::K_ERROR;
                    end
                end
                PH_LAST: begin
                    if (c == hcbd_pkg::CH_CR) begin
                        n_phase = PH_LAST_LF;
                    end else if (c == hcbd_pkg::CH_LF) begin
                        n_phase       = PH_DONE;
                        o_result.kind = hcbd_pkg::K_DONE;
                    end else begin
                        n_phase       = PH_ERR;
                        o_result.kind = hcbd_pkg::K_ERROR;
                    end
                end
                PH_LAST_LF: begin
                    if (c == hcbd_pkg::CH_LF) begin
                        n_phase       = PH_DONE;
                        o_result.kind = hcbd_pkg::K_DONE;
                    end else begin
                        n_phase       = PH_ERR;
                        o_result.kind = hcbd_pkg::K_ERROR;
                    end
                end
                PH_DONE: begin
                    o_result.kind         = hcbd_pkg::K_LEFT;
                    o_result.payload_byte = c;
                end
                default: begin
                    n_phase       = PH_ERR;
                    o_result.kind = hcbd_pkg::K_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_remaining <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
        end
    end

`ifndef SYNTH
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == hcbd_pkg::ACT_BYTE && r_phase == PH_ERR
        |=> r_phase == PH_ERR)
        else $error("error phase left without restart");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == hcbd_pkg::ACT_RESTART
        |=> r_phase == PH_LEN && r_remaining == '0)
        else $error("restart did not clear the parser");

    a_last_ends_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.chunk_last
        |=> r_phase == PH_DATA_END && r_remaining == '0)
        else $error("chunk end marker without framing phase");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == hcbd_pkg::ACT_BYTE && r_phase == PH_DATA
        && r_remaining > LW'(1)
        |=> r_phase == PH_DATA && r_remaining == $past(r_remaining) - LW'(1))
        else $error("payload counter did not decrement");
`endif
endmodule

// ===== rtl/hcbd_out_stage.sv =====
`timescale 1ns / 1ps
// Result register: holds one classified transaction until the sink takes it.
// Depends on hcbd_pkg.
module hcbd_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hcbd_pkg::t_result   i_result,
    output logic                o_space,
    output logic                o_valid,
    output hcbd_pkg::t_result   o_result,
    input  logic                i_ready
);
    logic              r_valid;
    hcbd_pkg::t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_valid;
        end
        if (o_space && i_valid) begin
            r_result <= i_result;
        end
    end
endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps
// HTTP/1.1 chunked body decoder: one byte per transaction in, one classified
// result per byte out (framing, payload with chunk-end mark, error, body complete,
// or leftover after the end). Throughput is one byte per clock while the output
// is ready; each byte passes the input register and then the result register,
// with the parser state updated in between. Input ready follows the output
// ready combinationally through both register stages. Hex lengths above
// hcbd_pkg::LENGTH_BITS bits, extensions and trailers raise a sticky error; a
// restart transaction clears the parser and yields one framing result.
// Depends on hcbd_pkg, hcbd_ifs, hcbd_in_stage, hcbd_core and hcbd_out_stage.
module http_chunked_body_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hcbd_in_if.sink      i_in,
    hcbd_out_if.source   o_out
);
    hcbd_pkg::t_item   in_item, stage_item;
    hcbd_pkg::t_result core_result, out_result;
    logic              stage_valid;
    logic              out_space;
    logic              fire;

    assign in_item.action  = i_in.action;
    assign in_item.in_byte = i_in.in_byte;
    assign fire            = stage_valid && out_space;

    hcbd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_ready (i_in.ready),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (out_space)
    );

    hcbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    hcbd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .i_result (core_result),
        .o_space  (out_space),
        .o_valid  (o_out.valid),
        .o_result (out_result),
        .i_ready  (o_out.ready)
    );

    assign o_out.kind         = out_result.kind;
    assign o_out.payload_byte = out_result.payload_byte;
    assign o_out.chunk_last   = out_result.chunk_last;
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for http_chunked_body_decoder: directed framing and
// error cases, then random chunked bodies under bursty input and stalled output.
// Depends on hcbd_pkg, hcbd_ifs and the decoder RTL.
module testbench;
    import hcbd_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int DRAIN_CYCLES  = 8;

    typedef enum logic [3:0] {
        ST_SIZE, ST_SIZE_LF, ST_BODY, ST_BODY_END, ST_BODY_LF,
        ST_FINAL, ST_FINAL_LF, ST_DONE, ST_FAIL
    } parse_st_t;

    logic i_clk;
    logic i_rst_n;

    hcbd_in_if  in_bus ();
    hcbd_out_if out_bus ();

    http_chunked_body_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // predictor state
    parse_st_t              parse_st;
    logic [LENGTH_BITS-1:0] chunk_left;
    t_result                byte_classes_due[$];

    int mismatches    = 0;
    int cycles        = 0;
    int items_sent    = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b1;
    int corrupt_in    = -1;
    int hold_request  = 0;
    int hold_left     = 0;
    int rx_cycle      = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Expected classification of one byte; advances the predictor state.
    function automatic t_result classify_byte(input t_action act, input logic [7:0] b);
        t_result    r;
        logic [4:0] digit;
        r.kind         = K_FRAME;
        r.payload_byte = 8'h00;
        r.chunk_last   = 1'b0;
        if (b >= "0" && b <= "9")      digit = 5'(b - "0");
        else if (b >= "a" && b <= "f") digit = 5'(b - "a" + 10);
        else if (b >= "A" && b <= "F") digit = 5'(b - "A" + 10);
        else                           digit = 5'd16;
        if (act == ACT_RESTART) begin
            parse_st   = ST_SIZE;
            chunk_left = '0;
        end else begin
            case (parse_st)
                ST_SIZE: begin
                    if (b == CH_CR) begin
                        parse_st = ST_SIZE_LF;
                    end else if (b == CH_LF) begin
                        parse_st = (chunk_left == '0) ? ST_FINAL : ST_BODY;
                    end else if (digit > 5'd15 || chunk_left[LENGTH_BITS-1 -: 4] != 4'd0) begin
                        parse_st = ST_FAIL;
                        r.kind   = K_ERROR;
                    end else begin
                        chunk_left = {chunk_left[LENGTH_BITS-5:0], digit[3:0]};
                    end
                end
                ST_SIZE_LF: begin
                    if (b == CH_LF) begin
                        parse_st = (chunk_left == '0) ? ST_FINAL : ST_BODY;
                    end else begin
                        parse_st = ST_FAIL;
                        r.kind   = K_ERROR;
                    end
                end
                ST_BODY: begin
                    r.kind         = K_PAYLOAD;
                    r.payload_byte = b;
                    if (chunk_left <= 1) begin
                        chunk_left   = '0;
                        r.chunk_last = 1'b1;
                        parse_st     = ST_BODY_END;
                    end else begin
                        chunk_left = chunk_left - 1'b1;
                    end
                end
                ST_BODY_END: begin
                    if (b == CH_CR) parse_st = ST_BODY_LF;
                    else if (b == CH_LF) parse_st = ST_SIZE;
                    else begin
                        parse_st = ST_FAIL;
                        r.kind   = K_ERROR;
                    end
                end
                ST_BODY_LF: begin
                    if (b == CH_LF) parse_st = ST_SIZE;
                    else begin
                        parse_st = ST_FAIL;
                        r.kind   = K_ERROR;
                    end
                end
                ST_FINAL: begin
                    if (b == CH_CR) parse_st = ST_FINAL_LF;
                    else if (b == CH_LF) begin
                        parse_st = ST_DONE;
                        r.kind   = K_DONE;
                    end else begin
                        parse_st = ST_FAIL;
                        r.kind   = K_ERROR;
                    end
                end
                ST_FINAL_LF: begin
                    if (b == CH_LF) begin
                        parse_st = ST_DONE;
                        r.kind   = K_DONE;
                    end else begin
                        parse_st = ST_FAIL;
                        r.kind   = K_ERROR;
                    end
                end
                ST_DONE: begin
                    r.kind         = K_LEFT;
                    r.payload_byte = b;
                end
                default: begin
                    parse_st = ST_FAIL;
                    r.kind   = K_ERROR;
                end
            endcase
        end
        return r;
    endfunction

    // One transaction on the input channel; called and returns at a falling edge.
    task automatic send_item(input t_action act, input logic [7:0] b);
        in_bus.action  = act;
        in_bus.in_byte = b;
        in_bus.valid   = 1'b1;
        forever begin
            @(posedge i_clk);
            if (in_bus.ready) break;
        end
        byte_classes_due.push_back(classify_byte(act, b));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Sender with random bursts and gaps; optionally corrupts one chosen byte.
    task automatic put_byte(input t_action act, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                in_bus.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if (corrupt_in == 0) b = 8'($urandom_range(0, 255));
        if (corrupt_in >= 0) corrupt_in--;
        send_item(act, b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(ACT_BYTE, s[i]);
    endtask

    task automatic send_eol();
        if ($urandom_range(0, 1)) put_byte(ACT_BYTE, CH_CR);
        put_byte(ACT_BYTE, CH_LF);
    endtask

    // Chunk size in hex, random letter case, sometimes with leading zeros.
    task automatic send_size(input int len);
        int         k;
        int         nib;
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 9)) put_byte(ACT_BYTE, "0");
        end
        k = 7;
        while (k > 0 && ((len >> (4 * k)) & 15) == 0) k--;
        for (int i = k; i >= 0; i--) begin
            nib = (len >> (4 * i)) & 15;
            if (nib < 10) c = 8'("0" + nib);
            else c = 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 10);
            put_byte(ACT_BYTE, c);
        end
    endtask

    // Chunks with random content and a last-chunk size line, random bytes, then restart.
    task automatic send_body(input int max_len);
        int len;
        repeat ($urandom_range(0, 4)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, max_len)
                                              : $urandom_range(1, 16);
            send_size(len);
            send_eol();
            repeat (len) put_byte(ACT_BYTE, 8'($urandom_range(0, 255)));
            send_eol();
        end
        repeat ($urandom_range(0, 3)) put_byte(ACT_BYTE, "0");
        send_eol();
        repeat ($urandom_range(0, 3)) put_byte(ACT_BYTE, 8'($urandom_range(0, 255)));
        put_byte(ACT_RESTART, 8'($urandom_range(0, 255)));
    endtask

    // Checker: each result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (byte_classes_due.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected: kind %0d byte %02h last %0b",
                         $time, out_bus.kind, out_bus.payload_byte, out_bus.chunk_last);
            end else begin
                want = byte_classes_due.pop_front();
                if (out_bus.kind !== want.kind) begin
                    mismatches++;
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                             out_bus.kind);
                end
                if (out_bus.payload_byte !== want.payload_byte) begin
                    mismatches++;
                    $display("%0t: payload_byte expected %02h actual %02h", $time,
                             want.payload_byte, out_bus.payload_byte);
                end
                if (out_bus.chunk_last !== want.chunk_last) begin
                    mismatches++;
                    $display("%0t: chunk_last expected %0b actual %0b", $time,
                             want.chunk_last, out_bus.chunk_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     byte_classes_due.size());
            $display("http_chunked_body_decoder verification failed");
            $finish;
        end
    end

    // Receiver: long hold-off on request, otherwise a rotating stall pattern
    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else begin
            case ((rx_cycle / 256) % 4)
                0: out_bus.ready <= 1'b1;
                1: out_bus.ready <= 1'($urandom_range(0, 1));
                2: out_bus.ready <= ((rx_cycle / 8) % 3) != 0;
                default: out_bus.ready <= $urandom_range(0, 4) != 0;
            endcase
        end
    end

    task automatic wait_all_results();
        while (byte_classes_due.size() != 0) @(negedge i_clk);
    endtask

    // LF-only size line, max-value payload, empty last-chunk size, leftover, restart
    task automatic test_framing();
        send_text("1");
        put_byte(ACT_BYTE, CH_LF);
        put_byte(ACT_BYTE, 8'hFF);
        put_byte(ACT_BYTE, CH_CR);
        put_byte(ACT_BYTE, CH_LF);
        put_byte(ACT_BYTE, CH_LF);
        put_byte(ACT_BYTE, CH_CR);
        put_byte(ACT_BYTE, CH_LF);
        put_byte(ACT_BYTE, 8'h00);
        put_byte(ACT_RESTART, 8'hFF);
    endtask

    // Size overflow, sticky error, bad byte in the size field
    task automatic test_errors();
        send_text("FFFFFFFFF");
        send_text("a");
        put_byte(ACT_RESTART, 8'h00);
        send_text("g");
        put_byte(ACT_RESTART, 8'h5A);
    endtask

    // Output held off for a long stretch while input keeps coming
    task automatic test_backpressure();
        gaps_on      = 1'b0;
        hold_request = 300;
        send_size(120);
        send_eol();
        repeat (120) put_byte(ACT_BYTE, 8'($urandom_range(0, 255)));
        send_eol();
        send_text("0");
        send_eol();
        put_byte(ACT_RESTART, 8'h00);
        gaps_on = 1'b1;
    endtask

    // Sender stops until everything has drained, then resumes
    task automatic test_drain_pause();
        send_body(32);
        in_bus.valid = 1'b0;
        wait_all_results();
        send_body(32);
    endtask

    task automatic test_random_bodies();
        int goal;
        int pick;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 19);
            gaps_on = ($urandom_range(0, 4) != 0);
            if (pick == 0) begin
                // oversized length, then a few bytes into the sticky error
                put_byte(ACT_BYTE, "1" + 8'($urandom_range(0, 8)));
                repeat ($urandom_range(8, 9)) send_text("f");
                repeat ($urandom_range(1, 3)) put_byte(ACT_BYTE, 8'($urandom_range(0, 255)));
                put_byte(ACT_RESTART, 8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                // raw noise with the odd restart mixed in
                repeat ($urandom_range(5, 20)) begin
                    put_byte(($urandom_range(0, 7) == 0) ? ACT_RESTART : ACT_BYTE,
                             8'($urandom_range(0, 255)));
                end
                put_byte(ACT_RESTART, 8'($urandom_range(0, 255)));
            end else begin
                // mostly well formed; some bodies get one corrupted byte
                corrupt_in = (pick < 5) ? $urandom_range(0, 40) : -1;
                send_body(48);
                corrupt_in = -1;
            end
        end
    endtask

    initial begin
        parse_st       = ST_SIZE;
        chunk_left     = '0;
        i_rst_n        = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.action  = ACT_BYTE;
        in_bus.in_byte = 8'h00;
        out_bus.ready  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_framing();
        test_errors();
        test_backpressure();
        test_drain_pause();
        test_random_bodies();

        in_bus.valid = 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("http_chunked_body_decoder verification clean");
        end else begin
            $display("http_chunked_body_decoder verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hcbd_pkg.sv
rtl/hcbd_ifs.sv
rtl/hcbd_in_stage.sv
rtl/hcbd_core.sv
rtl/hcbd_out_stage.sv
rtl/http_chunked_body_decoder.sv
tb/testbench.sv
